// ----- rtl/cmap_lex_pkg.sv -----
// Package for the CMap token lexer: request and result types, token kinds
// and the character codes the scanner looks for. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmap_lex_pkg;

  // Token kinds as carried on the result channel
  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_NUMBER  = 3'd1,
    KIND_HEX     = 3'd2,
    KIND_NAME    = 3'd3,
    KIND_ARRAY   = 3'd4,
    KIND_DICT    = 3'd5,
    KIND_BADLT   = 3'd6
  } tok_kind_e;

  // Character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF_HEX  = 8'h66;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;

  // One input request
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  // One result
  typedef struct packed {
    tok_kind_e  token_kind;
    logic [7:0] text_byte;
    logic       has_text;
    logic       token_last;
    logic       text_overflow;
    logic       end_seen;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/cmap_lex_if.sv -----
// Valid/ready channel interfaces for the lexer's byte input and result
// output. Depends on cmap_lex_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cmap_lex_in_if
  import cmap_lex_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface cmap_lex_out_if
  import cmap_lex_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] text_byte;
  logic       has_text;
  logic       token_last;
  logic       text_overflow;
  logic       end_seen;

  modport source (output valid, output token_kind, output text_byte, output has_text,
                  output token_last, output text_overflow, output end_seen,
                  input ready);
  modport sink   (input valid, input token_kind, input text_byte, input has_text,
                  input token_last, input text_overflow, input end_seen,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/cmap_lex_in_reg.sv -----
// Input register stage: holds one byte request until the scanner takes it.
// Depends on cmap_lex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmap_lex_in_reg
  import cmap_lex_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire in_item_t item_i,
  input  wire logic     take_i,     // scanner consumes the held request
  output logic          valid_o,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  // Free when empty or when the held request leaves this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ----- rtl/cmap_lex_core.sv -----
// Scanner core: mode, text length and overflow state, plus the next-state
// and result logic for one byte. Depends on cmap_lex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmap_lex_core
  import cmap_lex_pkg::*;
#(
  parameter int unsigned MAX_TOKEN_LEN = 1023
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,     // process item_i this cycle
  input  wire in_item_t item_i,
  output logic          res_valid_o,
  output out_item_t     res_o
);

  localparam int unsigned LenW = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_TOKEN_LEN);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_LT      = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_NUMBER  = 3'd4,
    MODE_NAME    = 3'd5,
    MODE_KEYWORD = 3'd6
  } mode_e;

  mode_e           mode_q, mode_d;
  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;

  logic       is_ws, is_hex, is_digit;
  logic       do_text, do_close, end_flag, idle_end;
  tok_kind_e  kind, mode_kind;
  mode_e      mode_next;
  logic [7:0] b;

  assign b        = item_i.in_byte;
  assign is_ws    = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  assign is_digit = (b >= CH_0) && (b <= CH_9);
  assign is_hex   = is_digit || (b >= CH_LA && b <= CH_LF_HEX) ||
                    (b >= CH_UA && b <= CH_UF);

  // Kind that a token in the current mode closes with
  always_comb begin
    unique case (mode_q)
      MODE_HEX:    mode_kind = KIND_HEX;
      MODE_NUMBER: mode_kind = KIND_NUMBER;
      MODE_NAME:   mode_kind = KIND_NAME;
      MODE_LT:     mode_kind = KIND_BADLT;
      default:     mode_kind = KIND_KEYWORD;
    endcase
  end

  // Decide what this byte does: text byte, token close, or nothing
  always_comb begin
    do_text   = 1'b0;
    do_close  = 1'b0;
    end_flag  = 1'b0;
    idle_end  = 1'b0;
    kind      = KIND_KEYWORD;
    mode_next = mode_q;
    if (item_i.stream_end) begin
      end_flag = 1'b1;
      if (mode_q == MODE_IDLE || mode_q == MODE_COMMENT) begin
        idle_end  = 1'b1;
        mode_next = MODE_IDLE;
      end else begin
        do_close = 1'b1;
        kind     = mode_kind;
      end
    end else begin
      unique case (mode_q)
        MODE_COMMENT: begin
          if (b == CH_CR || b == CH_LF) mode_next = MODE_IDLE;
        end
        MODE_LT: begin
          if (b == CH_LT) begin
            do_close = 1'b1;
            kind     = KIND_DICT;
          end else if (is_hex) begin
            do_text   = 1'b1;
            kind      = KIND_HEX;
            mode_next = MODE_HEX;
          end else begin
            do_close = 1'b1;
            kind     = KIND_BADLT;
          end
        end
        MODE_HEX: begin
          kind = KIND_HEX;
          if (b == CH_GT) do_close = 1'b1;
          else            do_text  = 1'b1;
        end
        MODE_NUMBER, MODE_NAME, MODE_KEYWORD: begin
          kind = mode_kind;
          if (is_ws) do_close = 1'b1;
          else       do_text  = 1'b1;
        end
        default: begin
          // idle: look for the start of a token
          if (is_ws) begin
            mode_next = MODE_IDLE;
          end else if (b == CH_PERCENT) begin
            mode_next = MODE_COMMENT;
          end else if (b == CH_LT) begin
            mode_next = MODE_LT;
          end else if (b == CH_LBRACK) begin
            do_close = 1'b1;
            kind     = KIND_ARRAY;
          end else if (b == CH_SLASH) begin
            mode_next = MODE_NAME;
          end else if (is_digit) begin
            do_text   = 1'b1;
            kind      = KIND_NUMBER;
            mode_next = MODE_NUMBER;
          end else begin
            do_text   = 1'b1;
            kind      = KIND_KEYWORD;
            mode_next = MODE_KEYWORD;
          end
        end
      endcase
    end
  end

  // Next state and result; idle always holds zero length and no overflow
  always_comb begin
    mode_d      = mode_next;
    len_d       = len_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;
    res_o       = '{token_kind: kind, text_byte: 8'h00, has_text: 1'b0,
                    token_last: 1'b0, text_overflow: ovf_q, end_seen: end_flag};
    if (idle_end) begin
      res_valid_o         = 1'b1;
      res_o.token_kind    = KIND_KEYWORD;
      res_o.text_overflow = 1'b0;
      len_d               = '0;
      ovf_d               = 1'b0;
    end else if (do_close) begin
      res_valid_o      = 1'b1;
      res_o.token_last = 1'b1;
      mode_d           = MODE_IDLE;
      len_d            = '0;
      ovf_d            = 1'b0;
    end else if (do_text) begin
      if (len_q >= LenMax) begin
        ovf_d = 1'b1;       // limit reached: drop the byte
      end else begin
        len_d          = len_q + LenW'(1);
        res_valid_o    = 1'b1;
        res_o.text_byte = b;
        res_o.has_text = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      len_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cmap_lex_out_reg.sv -----
// Result register: holds one result until the output side takes it.
// Depends on cmap_lex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmap_lex_out_reg
  import cmap_lex_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,    // a scanner step completes this cycle
  input  wire logic      res_valid_i,
  input  wire out_item_t res_i,
  output logic           free_o,    // can accept a scanner step
  output logic           valid_o,
  input  wire logic      ready_i,
  output out_item_t      item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) valid_d = load_i && res_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (free_o && load_i && res_valid_i) begin
      item_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ----- rtl/cmap_token_lexer_unit.sv -----
// CMap token lexer top level: input register, scanner core, result register.
// An accepted byte request waits in the input register; it is scanned when the
// result register is free. One byte per cycle while the result channel is not stalled.
// A byte that yields no result still takes its slot in the scanner.
// Reset (rst_ni, asynchronous, active low): both channels empty, scanner idle.
// Depends on cmap_lex_pkg, cmap_lex_if, cmap_lex_in_reg, cmap_lex_core, cmap_lex_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module cmap_token_lexer_unit
  import cmap_lex_pkg::*;
#(
  parameter int unsigned MAX_TOKEN_LEN = 1023
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  cmap_lex_in_if.sink    in_i,
  cmap_lex_out_if.source out_o
);

  in_item_t  in_item, held_item;
  logic      held_valid, out_free, step;
  logic      res_valid;
  out_item_t res, out_item;

  assign in_item = '{in_byte: in_i.in_byte, stream_end: in_i.stream_end};

  // The held request is scanned whenever the result register can take it
  assign step = held_valid && out_free;

  cmap_lex_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .take_i  (step),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  cmap_lex_core #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cmap_lex_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .item_o      (out_item)
  );

  // Drive the result channel fields
  assign out_o.token_kind    = out_item.token_kind;
  assign out_o.text_byte     = out_item.text_byte;
  assign out_o.has_text      = out_item.has_text;
  assign out_o.token_last    = out_item.token_last;
  assign out_o.text_overflow = out_item.text_overflow;
  assign out_o.end_seen      = out_item.end_seen;

endmodule

`default_nettype wire

// ----- rtl/cmap_lex_checker.sv -----
// Port-level checks on the lexer's result channel, bound to the top level.
// Depends on cmap_lex_pkg and cmap_token_lexer_unit.
`timescale 1ns / 1ps
`default_nettype none

module cmap_lex_checker
  import cmap_lex_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] token_kind_i,
  input wire logic [7:0] text_byte_i,
  input wire logic       has_text_i,
  input wire logic       token_last_i,
  input wire logic       text_overflow_i,
  input wire logic       end_seen_i
);

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({token_kind_i, text_byte_i, has_text_i, token_last_i,
               text_overflow_i, end_seen_i}))
    else $error("result changed while stalled");

  // A text byte never closes a token or answers end of stream
  a_text_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && has_text_i |-> !token_last_i && !end_seen_i)
    else $error("text byte marked as token end");

  // Closing and end items carry no text byte
  a_no_text_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_text_i |-> text_byte_i == 8'h00)
    else $error("non-text item with nonzero byte");

  // Every result either carries text, closes a token or answers end of stream
  a_item_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> has_text_i || token_last_i || end_seen_i)
    else $error("empty result item");

  // End of stream outside a token: plain keyword-coded item, no overflow
  a_idle_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && end_seen_i && !token_last_i |->
      token_kind_i == KIND_KEYWORD && !text_overflow_i)
    else $error("bad end-of-stream item while idle");

endmodule

bind cmap_token_lexer_unit cmap_lex_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .token_kind_i    (out_o.token_kind),
  .text_byte_i     (out_o.text_byte),
  .has_text_i      (out_o.has_text),
  .token_last_i    (out_o.token_last),
  .text_overflow_i (out_o.text_overflow),
  .end_seen_i      (out_o.end_seen)
);

`default_nettype wire

// ----- tb/sv/tb_cmap_lex_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the CMap token lexer: watches the byte request and result
// channels, predicts every result and compares it. Depends on cmap_lex_pkg, cmap_lex_if.

module tb_cmap_lex_checker
  import cmap_lex_pkg::*;
#(
  parameter int unsigned MAX_TOKEN_LEN = 1023
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cmap_lex_in_if    req_i,
  cmap_lex_out_if   res_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o,
  output int        tokens_o,
  output int        overflows_o,
  output int        ends_o
);

  // Scanner position between bytes
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_COMMENT,
    SCAN_LT,
    SCAN_HEX,
    SCAN_NUMBER,
    SCAN_NAME,
    SCAN_KEYWORD
  } scan_mode_e;

  scan_mode_e  mode_q;
  int unsigned text_len_q;
  logic        dropped_q;
  out_item_t   lexed_q[$];

  function automatic logic is_space(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_hex_digit(input logic [7:0] b);
    return (b >= CH_0 && b <= CH_9) || (b >= CH_LA && b <= CH_LF_HEX) ||
           (b >= CH_UA && b <= CH_UF);
  endfunction

  function automatic tok_kind_e kind_of(input scan_mode_e m);
    case (m)
      SCAN_HEX:    return KIND_HEX;
      SCAN_NUMBER: return KIND_NUMBER;
      SCAN_NAME:   return KIND_NAME;
      SCAN_LT:     return KIND_BADLT;
      default:     return KIND_KEYWORD;
    endcase
  endfunction

  function automatic void push_result(input tok_kind_e k, input logic [7:0] t,
                                      input logic has, input logic last,
                                      input logic ovf, input logic fin);
    out_item_t r;
    r.token_kind    = k;
    r.text_byte     = t;
    r.has_text      = has;
    r.token_last    = last;
    r.text_overflow = ovf;
    r.end_seen      = fin;
    lexed_q.push_back(r);
  endfunction

  function automatic void back_to_idle();
    mode_q     = SCAN_IDLE;
    text_len_q = 0;
    dropped_q  = 1'b0;
  endfunction

  // Text byte, or silently dropped once the token is at its length limit
  function automatic void add_text(input tok_kind_e k, input logic [7:0] b);
    if (text_len_q >= MAX_TOKEN_LEN) begin
      dropped_q = 1'b1;
    end else begin
      text_len_q++;
      push_result(k, b, 1'b1, 1'b0, dropped_q, 1'b0);
    end
  endfunction

  function automatic void close_tok(input tok_kind_e k, input logic fin);
    push_result(k, 8'h00, 1'b0, 1'b1, dropped_q, fin);
    back_to_idle();
  endfunction

  // Advance the predicted scanner by one byte request
  function automatic void scan_byte(input logic [7:0] b, input logic fin);
    if (fin) begin
      if (mode_q == SCAN_IDLE || mode_q == SCAN_COMMENT) begin
        push_result(KIND_KEYWORD, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        back_to_idle();
      end else begin
        close_tok(kind_of(mode_q), 1'b1);
      end
      return;
    end
    case (mode_q)
      SCAN_COMMENT: begin
        if (b == CH_CR || b == CH_LF) back_to_idle();
        return;
      end
      SCAN_LT: begin
        if (b == CH_LT) begin
          close_tok(KIND_DICT, 1'b0);
        end else if (is_hex_digit(b)) begin
          mode_q = SCAN_HEX;
          add_text(KIND_HEX, b);
        end else begin
          // the byte after a bad '<' is swallowed
          close_tok(KIND_BADLT, 1'b0);
        end
        return;
      end
      SCAN_HEX: begin
        if (b == CH_GT) close_tok(KIND_HEX, 1'b0);
        else add_text(KIND_HEX, b);
        return;
      end
      SCAN_NUMBER, SCAN_NAME, SCAN_KEYWORD: begin
        if (is_space(b)) close_tok(kind_of(mode_q), 1'b0);
        else add_text(kind_of(mode_q), b);
        return;
      end
      default: ;
    endcase
    // idle: look for the start of a token
    back_to_idle();
    if (is_space(b)) return;
    if (b == CH_PERCENT) begin
      mode_q = SCAN_COMMENT;
    end else if (b == CH_LT) begin
      mode_q = SCAN_LT;
    end else if (b == CH_LBRACK) begin
      close_tok(KIND_ARRAY, 1'b0);
    end else if (b == CH_SLASH) begin
      mode_q = SCAN_NAME;
    end else if (b >= CH_0 && b <= CH_9) begin
      mode_q = SCAN_NUMBER;
      add_text(KIND_NUMBER, b);
    end else begin
      mode_q = SCAN_KEYWORD;
      add_text(KIND_KEYWORD, b);
    end
  endfunction

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    out_item_t got;
    out_item_t want;
    if (!rst_ni) begin
      back_to_idle();
      lexed_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      tokens_o     <= 0;
      overflows_o  <= 0;
      ends_o       <= 0;
    end else begin
      if (req_i.valid && req_i.ready) scan_byte(req_i.in_byte, req_i.stream_end);
      if (res_i.valid && res_i.ready) begin
        got.token_kind    = tok_kind_e'(res_i.token_kind);
        got.text_byte     = res_i.text_byte;
        got.has_text      = res_i.has_text;
        got.token_last    = res_i.token_last;
        got.text_overflow = res_i.text_overflow;
        got.end_seen      = res_i.end_seen;
        checked_o <= checked_o + 1;
        if (got.token_last) tokens_o <= tokens_o + 1;
        if (got.token_last && got.text_overflow) overflows_o <= overflows_o + 1;
        if (got.end_seen) ends_o <= ends_o + 1;
        if (lexed_q.size() == 0) begin
          $display("%0t: result with nothing outstanding: kind=%0d text=%h has=%b last=%b ovf=%b end=%b",
                   $time, got.token_kind, got.text_byte, got.has_text, got.token_last,
                   got.text_overflow, got.end_seen);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = lexed_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected kind=%0d text=%h has=%b last=%b ovf=%b end=%b",
                     $time, want.token_kind, want.text_byte, want.has_text, want.token_last,
                     want.text_overflow, want.end_seen);
            $display("%0t:          actual   kind=%0d text=%h has=%b last=%b ovf=%b end=%b",
                     $time, got.token_kind, got.text_byte, got.has_text, got.token_last,
                     got.text_overflow, got.end_seen);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= lexed_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_cmap_token_lexer_unit.sv -----
`timescale 1ns / 1ps
// Top of the CMap token lexer testbench: clock, reset, byte request stimulus,
// result back-pressure and the verdict. Depends on cmap_lex_pkg, cmap_lex_if, tb_cmap_lex_checker.

module tb_cmap_token_lexer_unit;
  import cmap_lex_pkg::*;

  localparam int unsigned TOKEN_MAX      = 1023;
  localparam int          RANDOM_HALF    = 370;
  localparam int          RX_HOLD_CYCLES = 250;
  localparam int          IDLE_LIMIT     = 3000;

  // hand-off between stimulus and receiver for the long hold-off
  localparam int HOLD_NONE      = 0;
  localparam int HOLD_REQUESTED = 1;
  localparam int HOLD_ACTIVE    = 2;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int   sent_count  = 0;
  int   idle_cycles = 0;
  int   rx_hold     = HOLD_NONE;
  logic tx_burst    = 1'b0;

  int fail_count, pending, checked, tokens, overflows, ends;

  always #5 clk_i = ~clk_i;

  cmap_lex_in_if  byte_if ();
  cmap_lex_out_if tok_if ();

  cmap_token_lexer_unit #(
    .MAX_TOKEN_LEN(TOKEN_MAX)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .out_o (tok_if)
  );

  tb_cmap_lex_checker #(
    .MAX_TOKEN_LEN(TOKEN_MAX)
  ) u_lex_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (byte_if),
    .res_i       (tok_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .tokens_o    (tokens),
    .overflows_o (overflows),
    .ends_o      (ends)
  );

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_ws();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] rand_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return CH_0 + 8'(r);
    if (r < 16) return CH_LA + 8'(r - 10);
    return CH_UA + 8'(r - 16);
  endfunction

  // any byte that is not whitespace
  function automatic logic [7:0] rand_solid();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR));
    return b;
  endfunction

  function automatic logic [7:0] rand_kw_start();
    logic [7:0] b;
    do b = rand_solid();
    while (b == CH_PERCENT || b == CH_LT || b == CH_LBRACK || b == CH_SLASH ||
           (b >= CH_0 && b <= CH_9));
    return b;
  endfunction

  // byte after '<' that makes it a bad token
  function automatic logic [7:0] rand_bad_follow();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_LT || (b >= CH_0 && b <= CH_9) || (b >= CH_LA && b <= CH_LF_HEX) ||
           (b >= CH_UA && b <= CH_UF));
    return b;
  endfunction

  function automatic logic [7:0] rand_hex_body();
    int         r;
    logic [7:0] b;
    r = $urandom_range(0, 9);
    if (r < 6) return rand_hex();
    if (r < 8) return rand_ws();
    do b = 8'($urandom_range(0, 255));
    while (b == CH_GT);
    return b;
  endfunction

  function automatic logic [7:0] rand_comment_body();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic int rand_text_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 24);
    return $urandom_range(25, 60);
  endfunction

  // One byte request; called and returning at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      byte_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_if.valid      = 1'b1;
    byte_if.in_byte    = b;
    byte_if.stream_end = fin;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
  endtask

  // in_byte is a don't-care on an end-of-stream request, so randomise it
  task automatic send_end();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_drained();
    byte_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Leading bytes of a text-bearing token; reports text bytes already sent
  task automatic open_token(input tok_kind_e kind, output int used);
    used = 1;
    case (kind)
      KIND_NUMBER: send_byte(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
      KIND_NAME: begin
        send_byte(CH_SLASH, 1'b0);
        used = 0;
      end
      KIND_HEX: begin
        send_byte(CH_LT, 1'b0);
        send_byte(rand_hex(), 1'b0);
      end
      default: send_byte(rand_kw_start(), 1'b0);
    endcase
  endtask

  task automatic text_bytes(input tok_kind_e kind, input int n);
    repeat (n) send_byte(kind == KIND_HEX ? rand_hex_body() : rand_solid(), 1'b0);
  endtask

  task automatic close_token(input tok_kind_e kind, input logic by_end);
    if (by_end) send_end();
    else if (kind == KIND_HEX) send_byte(CH_GT, 1'b0);
    else send_byte(rand_ws(), 1'b0);
  endtask

  function automatic tok_kind_e rand_text_kind();
    case ($urandom_range(0, 3))
      0:       return KIND_NUMBER;
      1:       return KIND_NAME;
      2:       return KIND_HEX;
      default: return KIND_KEYWORD;
    endcase
  endfunction

  // Token of exactly n text bytes, to probe the length limit
  task automatic long_token(input int n, input logic by_end);
    tok_kind_e kind;
    int        used;
    kind = rand_text_kind();
    open_token(kind, used);
    text_bytes(kind, n - used);
    close_token(kind, by_end);
  endtask

  // One random stretch of the stream: mostly well-formed tokens, some noise
  task automatic gen_sequence();
    int        r;
    int        used;
    tok_kind_e kind;
    r        = $urandom_range(0, 99);
    tx_burst = ($urandom_range(0, 7) == 0);
    if (r < 56) begin
      kind = rand_text_kind();
      open_token(kind, used);
      text_bytes(kind, rand_text_len());
      close_token(kind, $urandom_range(0, 11) == 0);
    end else if (r < 62) begin
      send_byte(CH_LT, 1'b0);
      send_byte(CH_LT, 1'b0);
    end else if (r < 68) begin
      send_byte(CH_LBRACK, 1'b0);
    end else if (r < 74) begin
      send_byte(CH_LT, 1'b0);
      if ($urandom_range(0, 6) == 0) send_end();
      else send_byte(rand_bad_follow(), 1'b0);
    end else if (r < 81) begin
      send_byte(CH_PERCENT, 1'b0);
      repeat (rand_text_len()) send_byte(rand_comment_body(), 1'b0);
      if ($urandom_range(0, 9) == 0) send_end();
      else send_byte($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
    end else if (r < 91) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(rand_ws(), 1'b0);
      if ($urandom_range(0, 7) == 0) send_end();
    end
    tx_burst = 1'b0;
  endtask

  // Result back-pressure: ready runs, random gaps, one long hold-off on request
  initial begin : drive_ready
    tok_if.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold == HOLD_REQUESTED) begin
        rx_hold      = HOLD_ACTIVE;
        tok_if.ready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
        rx_hold = HOLD_NONE;
      end else begin
        tok_if.ready = 1'b1;
        repeat ($urandom_range(1, 40)) @(negedge clk_i);
        if (rx_hold == HOLD_NONE) begin : rx_gap
          int gap;
          gap = pick_gap();
          if (gap > 0) begin
            tok_if.ready = 1'b0;
            repeat (gap) @(negedge clk_i);
          end
        end
      end
    end
  end

  // Watchdog: stop if neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_if.valid && byte_if.ready) || (tok_if.valid && tok_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog: no request or result moved for %0d cycles, %0d outstanding",
                 $time, IDLE_LIMIT, pending);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int stop_at;
    byte_if.valid      = 1'b0;
    byte_if.in_byte    = 8'h00;
    byte_if.stream_end = 1'b0;
    rst_ni             = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // byte extremes make a keyword
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    // comment skipped, scanning resumes afterwards
    send_byte(CH_PERCENT, 1'b0);
    send_byte("x", 1'b0);
    send_byte(CH_LF, 1'b0);
    // name without its slash, number closed by CR
    send_byte(CH_SLASH, 1'b0);
    send_byte("A", 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte("7", 1'b0);
    send_byte(CH_CR, 1'b0);
    // hex string keeps its inner whitespace
    send_byte(CH_LT, 1'b0);
    send_byte("a", 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_GT, 1'b0);
    // dict open, array, bad '<' swallowing its follower
    send_byte(CH_LT, 1'b0);
    send_byte(CH_LT, 1'b0);
    send_byte(CH_LBRACK, 1'b0);
    send_byte(CH_LT, 1'b0);
    send_byte("z", 1'b0);
    // stream end right after '<', while idle, in a comment, inside a token
    send_byte(CH_LT, 1'b0);
    send_end();
    send_end();
    send_byte(CH_PERCENT, 1'b0);
    send_end();
    send_byte("k", 1'b0);
    send_end();
    wait_drained();

    while (sent_count < RANDOM_HALF) gen_sequence();
    wait_drained();

    // length limit: runs up to it, then a few bytes past it are dropped
    long_token(TOKEN_MAX + $urandom_range(1, 4), 1'(($urandom_range(0, 1))));

    // receiver holds off while requests keep coming at full rate
    byte_if.valid = 1'b0;
    rx_hold = HOLD_REQUESTED;
    while (rx_hold != HOLD_ACTIVE) @(negedge clk_i);
    tx_burst = 1'b1;
    send_byte(rand_kw_start(), 1'b0);
    text_bytes(KIND_KEYWORD, 60);
    send_byte(rand_ws(), 1'b0);
    tx_burst = 1'b0;

    stop_at = sent_count + RANDOM_HALF;
    while (sent_count < stop_at) gen_sequence();
    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("%0d byte requests driven, %0d results checked", sent_count, checked);
    $display("%0d tokens closed, %0d past the length limit, %0d stream ends answered",
             tokens, overflows, ends);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
